// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/sma_pkg.sv -----
`default_nettype none

package sma_pkg;

  localparam int DATA_W        = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int CHAR_W        = 8;
  localparam int DEPTH_OUT_W   = 7;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 56;
  localparam int STEP_W        = $clog2(DATA_W);
  localparam int STACK_DEPTH_DEF = 64;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DATA_W-1:0]   word_t;

  localparam cmd_t CMD_PUSH  = 3'd0;
  localparam cmd_t CMD_SUB   = 3'd1;
  localparam cmd_t CMD_DIV   = 3'd2;
  localparam cmd_t CMD_MUL   = 3'd3;
  localparam cmd_t CMD_MOD   = 3'd4;
  localparam cmd_t CMD_PCHAR = 3'd5;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_SHORT   = 2'd1;
  localparam status_t ST_DIVZERO = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/core/stack_machine_alu.sv -----
// Channel | Direction | Ports             | tdata fields, lowest bit first
// in_     | slave     | tvalid/tready/tdata | command[2:0], push_value[34:3], zero pad
// out_    | master    | tvalid/tready/tdata | status[1:0], top_value[33:2],
//         |           |                     | char_out[41:34], char_valid[42],
//         |           |                     | stack_depth[49:43], zero pad
// Request paths: push, pchar, unused codes, short and full stack go straight to S_FIN;
//   sub and zero divisor pass through S_RD; mul, div and mod also run the 32-step
//   shift-add / restoring loop in S_EXEC.
// Top of stack sits in a register; the entry below comes from the stack RAM
//   through a registered read.
// Reset (rst_n, synchronous) empties the stack; RAM contents are not cleared.
// A new request is taken while a previous result still waits on out_.
// A finished request waits in its last cycle while out_ is stalled.
`default_nettype none

`include "assert_macros.svh"

module stack_machine_alu #(
  parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // command, push_value, pad
  input  wire logic [sma_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // status, top_value, char_out, char_valid, stack_depth, pad
  output logic [sma_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import sma_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  word_t mem [STACK_DEPTH];

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            top_r, top_nxt;
  cmd_t             cmd_r, cmd_nxt;
  word_t            pv_r, pv_nxt;
  status_t          status_r, status_nxt;
  word_t            acc_r, acc_nxt;
  word_t            q_r, q_nxt;
  word_t            opd_r, opd_nxt;
  logic             neg_q_r, neg_q_nxt;
  logic             neg_r_r, neg_r_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  word_t            rdata_r;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic             in_acc;
  cmd_t             in_cmd;
  word_t            in_pv;
  logic             is_bin;
  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             commit;
  logic             mem_we;
  word_t            acc_sh, mul_add, rem_sh;
  logic [DATA_W:0]  diff;
  word_t            s_v, t_v, res;
  word_t            fin_top;
  logic [CNT_W-1:0] fin_cnt;
  logic [CHAR_W-1:0] fin_char;
  logic             fin_cval;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_cmd    = in_tdata[CMD_W-1:0];
  assign in_pv     = in_tdata[CMD_W+DATA_W-1:CMD_W];
  assign is_bin    = (in_cmd == CMD_SUB) || (in_cmd == CMD_DIV) ||
                     (in_cmd == CMD_MUL) || (in_cmd == CMD_MOD);

  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign cnt_m2  = cnt_r - CNT_W'(2);
  assign wr_addr = cnt_m1[AW-1:0];
  assign rd_addr = cnt_m2[AW-1:0];

  assign commit = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign mem_we = commit && (status_r == ST_OK) && (cmd_r == CMD_PUSH) &&
                  (cnt_r != '0);

  assign acc_sh  = {acc_r[DATA_W-2:0], 1'b0};
  assign mul_add = acc_sh + (q_r[DATA_W-1] ? opd_r : '0);
  assign rem_sh  = {acc_r[DATA_W-2:0], q_r[DATA_W-1]};
  assign diff    = {1'b0, rem_sh} - {1'b0, opd_r};

  assign s_v = rdata_r;
  assign t_v = top_r;

  always_comb begin
    case (cmd_r)
      CMD_DIV: res = neg_q_r ? (word_t'(0) - q_r) : q_r;
      CMD_MOD: res = neg_r_r ? (word_t'(0) - acc_r) : acc_r;
      default: res = acc_r;
    endcase
  end

  always_comb begin
    fin_top  = top_r;
    fin_cnt  = cnt_r;
    fin_char = '0;
    fin_cval = 1'b0;
    if (status_r == ST_OK) begin
      case (cmd_r)
        CMD_PUSH: begin
          fin_top = pv_r;
          fin_cnt = cnt_r + CNT_W'(1);
        end
        CMD_SUB, CMD_DIV, CMD_MUL, CMD_MOD: begin
          fin_top = res;
          fin_cnt = cnt_m1;
        end
        CMD_PCHAR: begin
          fin_char = top_r[CHAR_W-1:0];
          fin_cval = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    top_nxt       = top_r;
    cmd_nxt       = cmd_r;
    pv_nxt        = pv_r;
    status_nxt    = status_r;
    acc_nxt       = acc_r;
    q_nxt         = q_r;
    opd_nxt       = opd_r;
    neg_q_nxt     = neg_q_r;
    neg_r_nxt     = neg_r_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_cmd;
          pv_nxt     = in_pv;
          status_nxt = ST_OK;
          state_nxt  = S_FIN;
          if (in_cmd == CMD_PUSH) begin
            if (cnt_r == CNT_W'(STACK_DEPTH)) status_nxt = ST_FULL;
          end else if (is_bin) begin
            if (cnt_r < CNT_W'(2)) status_nxt = ST_SHORT;
            else state_nxt = S_RD;
          end else if (in_cmd == CMD_PCHAR) begin
            if (cnt_r == '0) status_nxt = ST_SHORT;
          end
        end
      end
      S_RD: begin
        step_nxt = '0;
        acc_nxt  = '0;
        if (((cmd_r == CMD_DIV) || (cmd_r == CMD_MOD)) && (t_v == '0)) begin
          status_nxt = ST_DIVZERO;
          state_nxt  = S_FIN;
        end else if (cmd_r == CMD_SUB) begin
          acc_nxt   = s_v - t_v;
          state_nxt = S_FIN;
        end else if (cmd_r == CMD_MUL) begin
          q_nxt     = t_v;
          opd_nxt   = s_v;
          state_nxt = S_EXEC;
        end else begin
          q_nxt     = s_v[DATA_W-1] ? (word_t'(0) - s_v) : s_v;
          opd_nxt   = t_v[DATA_W-1] ? (word_t'(0) - t_v) : t_v;
          neg_q_nxt = s_v[DATA_W-1] ^ t_v[DATA_W-1];
          neg_r_nxt = s_v[DATA_W-1];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        step_nxt = step_r + STEP_W'(1);
        if (cmd_r == CMD_MUL) begin
          acc_nxt = mul_add;
          q_nxt   = {q_r[DATA_W-2:0], 1'b0};
        end else if (!diff[DATA_W]) begin
          acc_nxt = diff[DATA_W-1:0];
          q_nxt   = {q_r[DATA_W-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh;
          q_nxt   = {q_r[DATA_W-2:0], 1'b0};
        end
        if (step_r == STEP_W'(DATA_W - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (commit) begin
          top_nxt       = fin_top;
          cnt_nxt       = fin_cnt;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {
            (OUT_TDATA_W - DEPTH_OUT_W - 1 - CHAR_W - DATA_W - STATUS_W)'(0),
            DEPTH_OUT_W'(fin_cnt),
            fin_cval,
            fin_char,
            (fin_cnt != '0) ? fin_top : word_t'(0),
            status_r
          };
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    cmd_r      <= cmd_nxt;
    pv_r       <= pv_nxt;
    status_r   <= status_nxt;
    acc_r      <= acc_nxt;
    q_r        <= q_nxt;
    opd_r      <= opd_nxt;
    neg_q_r    <= neg_q_nxt;
    neg_r_r    <= neg_r_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  // entries below the top of stack
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= top_r;
    end
    rdata_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SMA_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `SMA_ASSERT(a_accept_leaves_idle, in_acc |=> (state_r != S_IDLE), "accept did not start work")
  `SMA_ASSERT(a_exec_cmd, (state_r == S_EXEC) |-> ((cmd_r == CMD_MUL) || (cmd_r == CMD_DIV) || (cmd_r == CMD_MOD)), "iterative loop on wrong command")
  `SMA_ASSERT(a_char_ok, commit && fin_cval |-> (status_r == ST_OK) && (cnt_r != '0), "char reported on failed request")
  `SMA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_valid_r && (cnt_r == '0), "reset did not clear control")

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sma_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int RANDOM_REQUESTS = 300;
  localparam int HOLD_AT_REQUEST = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;

  // codes with no operation behind them
  localparam cmd_t CMD_NOP_A = 3'd6;
  localparam cmd_t CMD_NOP_B = 3'd7;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} seq_mode_t;

  typedef struct {
    cmd_t        cmd;
    word_t       value;
    int unsigned gap;
  } alu_request_t;

  typedef struct {
    status_t    status;
    word_t      top;
    logic [7:0] chr;
    logic       chr_valid;
    logic [6:0] depth;
  } alu_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  alu_request_t request_q[$];
  alu_result_t  alu_results_q[$];

  word_t       stack_mem[DEPTH];
  int          stack_count = 0;
  int          est_depth = 0;
  int          total_requests = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          error_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  logic        hold_done = 1'b0;

  stack_machine_alu u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) begin
      case ($urandom_range(0, 4))
        0: return 32'h0000_0001;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        3: return 32'h7FFF_FFFF;
        default: return 32'h0000_0002;
      endcase
    end
    if (r < 50) return word_t'($urandom_range(0, 40)) - 32'd20;
    return $urandom;
  endfunction

  function automatic cmd_t pick_op();
    return cmd_t'($urandom_range(CMD_SUB, CMD_PCHAR));
  endfunction

  // rough depth tracking only steers the generator
  task automatic queue_request(input cmd_t cmd, input word_t value, input int unsigned gap);
    alu_request_t req;
    req.cmd = cmd;
    req.value = value;
    req.gap = gap;
    request_q.push_back(req);
    if (cmd == CMD_PUSH && est_depth < DEPTH) est_depth++;
    else if (cmd >= CMD_SUB && cmd <= CMD_MOD && est_depth >= 2) est_depth--;
  endtask

  task automatic execute_command(input cmd_t cmd, input word_t value);
    alu_result_t res;
    word_t t, s, r, ms, mt, q;
    res.status = ST_OK;
    res.chr = '0;
    res.chr_valid = 1'b0;
    case (cmd)
      CMD_PUSH: begin
        if (stack_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stack_mem[stack_count] = value;
          stack_count++;
        end
      end
      CMD_SUB, CMD_DIV, CMD_MUL, CMD_MOD: begin
        if (stack_count < 2) begin
          res.status = ST_SHORT;
        end else begin
          t = stack_mem[stack_count-1];
          s = stack_mem[stack_count-2];
          if ((cmd == CMD_DIV || cmd == CMD_MOD) && t == '0) begin
            res.status = ST_DIVZERO;
          end else begin
            ms = s[31] ? -s : s;
            mt = t[31] ? -t : t;
            case (cmd)
              CMD_SUB: r = s - t;
              CMD_MUL: r = s * t;
              CMD_DIV: begin
                q = ms / mt;
                r = (s[31] ^ t[31]) ? -q : q;
              end
              default: begin
                q = ms % mt;
                r = s[31] ? -q : q;
              end
            endcase
            stack_mem[stack_count-2] = r;
            stack_count--;
          end
        end
      end
      CMD_PCHAR: begin
        if (stack_count == 0) begin
          res.status = ST_SHORT;
        end else begin
          res.chr = stack_mem[stack_count-1][7:0];
          res.chr_valid = 1'b1;
        end
      end
      default: ;
    endcase
    res.top = (stack_count != 0) ? stack_mem[stack_count-1] : '0;
    res.depth = stack_count[6:0];
    alu_results_q.push_back(res);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR result %0d %s: got %h expected %h", checked_count, field, got, want);
    error_count++;
  endtask

  // request driver
  always @(posedge clk) begin : drive
    alu_request_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        execute_command(in_tdata[2:0], in_tdata[34:3]);
        sent_count <= sent_count + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          in_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (request_q.size() != 0) begin
          req = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {5'b0, req.value, req.cmd};
          gap_left <= req.gap;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure, one long hold-off mid-run
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (!hold_done && sent_count >= HOLD_AT_REQUEST) begin
      out_tready <= 1'b0;
      stall_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (cycle_count[10:9] == 2'b00 || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // result monitor
  always @(posedge clk) begin : watch
    alu_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (alu_results_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[33:2], '0);
      end else begin
        want = alu_results_q.pop_front();
        if (out_tdata[1:0] != want.status)
          report_mismatch("status", 32'(out_tdata[1:0]), 32'(want.status));
        if (out_tdata[33:2] != want.top)
          report_mismatch("top_value", out_tdata[33:2], want.top);
        if (out_tdata[41:34] != want.chr)
          report_mismatch("char_out", 32'(out_tdata[41:34]), 32'(want.chr));
        if (out_tdata[42] != want.chr_valid)
          report_mismatch("char_valid", 32'(out_tdata[42]), 32'(want.chr_valid));
        if (out_tdata[49:43] != want.depth)
          report_mismatch("stack_depth", 32'(out_tdata[49:43]), 32'(want.depth));
      end
      checked_count++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("stack_machine_alu test failed");
    $finish;
  end

  initial begin
    seq_mode_t   mode;
    int          seg_len;
    int          rand_count;
    logic        quiet;
    cmd_t        cmd;
    int unsigned r;

    // short stack, unused codes, zero divisor, wrap cases
    queue_request(CMD_PCHAR, '0, 0);
    queue_request(CMD_SUB, '0, 1);
    queue_request(CMD_NOP_A, 32'hFFFF_FFFF, 0);
    queue_request(CMD_NOP_B, 32'h5555_5555, 0);
    queue_request(CMD_PUSH, 32'h7FFF_FFFF, 0);
    queue_request(CMD_DIV, '0, 0);
    queue_request(CMD_MUL, '0, 2);
    queue_request(CMD_MOD, '0, 0);
    queue_request(CMD_PUSH, '0, 0);
    queue_request(CMD_DIV, '0, 0);
    queue_request(CMD_MOD, '0, 0);
    queue_request(CMD_SUB, '0, 0);
    queue_request(CMD_PCHAR, '0, 0);
    queue_request(CMD_PUSH, 32'h8000_0000, 0);
    queue_request(CMD_PUSH, 32'hFFFF_FFFF, 0);
    queue_request(CMD_DIV, '0, 0);
    queue_request(CMD_PUSH, 32'hFFFF_FFFF, 0);
    queue_request(CMD_MOD, '0, 0);
    queue_request(CMD_MUL, '0, 0);
    queue_request(CMD_PUSH, 32'hFFFF_FFF9, 0);
    queue_request(CMD_PUSH, 32'h0000_0002, 0);
    queue_request(CMD_MOD, '0, 0);
    queue_request(CMD_PUSH, 32'h8000_0000, 0);
    queue_request(CMD_SUB, '0, 0);
    queue_request(CMD_PCHAR, '0, 0);
    // fill past the top for the full-stack case
    repeat (DEPTH + 2) queue_request(CMD_PUSH, pick_value(), 0);
    queue_request(CMD_PCHAR, '0, 0);

    rand_count = 0;
    while (rand_count < RANDOM_REQUESTS) begin
      mode = seq_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(8, 40);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        r = $urandom_range(0, 99);
        case (mode)
          MODE_GROW:   cmd = (r < 80) ? CMD_PUSH : pick_op();
          MODE_SHRINK: cmd = (r < 80 && est_depth >= 2) ? pick_op() : CMD_PUSH;
          MODE_MIXED:  cmd = (est_depth < 2 || r < 45) ? CMD_PUSH : pick_op();
          default:     cmd = cmd_t'($urandom_range(0, 7));
        endcase
        queue_request(cmd, pick_value(), quiet ? 0 : pick_gap());
        rand_count++;
      end
    end
    total_requests = request_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count != total_requests || alu_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("stack_machine_alu test passed");
    end else begin
      $display("stack_machine_alu test failed");
    end
    $finish;
  end

endmodule
